// ----- rtl/ddo_pkg.sv -----
// shared types, constants and fixed-point helpers for the odometry block
package ddo_pkg;

  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_MPC     = 3'd0;
  localparam logic [2:0] REG_IWB     = 3'd1;
  localparam logic [2:0] REG_THR     = 3'd2;
  localparam logic [2:0] REG_IPER    = 3'd3;
  localparam logic [2:0] REG_START_X = 3'd4;
  localparam logic [2:0] REG_START_Y = 3'd5;
  localparam logic [2:0] REG_START_H = 3'd6;

  localparam logic [31:0] RST_MPC  = 32'd661140;
  localparam logic [23:0] RST_IWB  = 24'd312076;
  localparam logic [30:0] RST_THR  = 31'd268435;
  localparam logic [15:0] RST_IPER = 16'd100;

  localparam logic signed [35:0] PI_Q28     = 36'sd843314857;
  localparam logic signed [35:0] TWO_PI_Q28 = 36'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic [32:0]        sum_mag;
    logic               sum_neg;
    logic [32:0]        dif_mag;
    logic               dif_neg;
    logic signed [31:0] lc;
    logic signed [31:0] rc;
    // yaw difference spans up to plus or minus two pi
    logic signed [33:0] imu;
  } ddo_item_t;

  // two correction steps cover every value the block can produce
  function automatic logic signed [35:0] wrap_pi(input logic signed [35:0] a);
    logic signed [35:0] v;
    v = a;
    for (int k = 0; k < 2; k++) begin
      if (v > PI_Q28) begin
        v = v - TWO_PI_Q28;
      end else if (v < -PI_Q28) begin
        v = v + TWO_PI_Q28;
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] sat_mag(input logic neg, input logic [66:0] m);
    if (!neg) begin
      return (m > 67'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
    return (m > 67'h80000000) ? 32'h80000000 : 32'(-m[31:0]);
  endfunction

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      5'd24: r = 34'sd63;
      5'd25: r = 34'sd31;
      5'd26: r = 34'sd15;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ddo_front.sv -----
// input stage: takes a word, forms sums, magnitudes and the imu turn
module ddo_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COUNT_BITS-1:0] in_left_count,
  input  logic signed [COUNT_BITS-1:0] in_right_count,
  input  logic signed [31:0]           in_yaw_prev,
  input  logic signed [31:0]           in_yaw_now,
  output logic                         q_push,
  output ddo_pkg::ddo_item_t           q_item,
  input  logic                         q_full
);
  import ddo_pkg::*;

  logic               f_valid_r, f_valid_nxt;
  ddo_item_t          f_item_r, f_item_nxt;
  logic signed [31:0] lc, rc;
  logic signed [32:0] sum, dif;
  logic signed [35:0] yp_w, yn_w, imu;
  logic               accept;

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_full;
  assign q_item   = f_item_r;

  always_comb begin
    lc   = 32'(in_left_count);
    rc   = 32'(in_right_count);
    sum  = 33'(lc) + 33'(rc);
    dif  = 33'(rc) - 33'(lc);
    yp_w = wrap_pi(36'(in_yaw_prev));
    yn_w = wrap_pi(36'(in_yaw_now));
    imu  = yn_w - yp_w;
    f_item_nxt.sum_neg = sum[32];
    f_item_nxt.sum_mag = sum[32] ? 33'(-sum) : 33'(sum);
    f_item_nxt.dif_neg = dif[32];
    f_item_nxt.dif_mag = dif[32] ? 33'(-dif) : 33'(dif);
    f_item_nxt.lc      = lc;
    f_item_nxt.rc      = rc;
    f_item_nxt.imu     = imu[33:0];
    f_valid_nxt = accept || (f_valid_r && !q_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ----- rtl/ddo_fifo.sv -----
// two-entry queue between the front and the back
module ddo_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ddo_pkg::ddo_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output ddo_pkg::ddo_item_t head_item
);
  import ddo_pkg::*;

  ddo_item_t   mem_r [2];
  logic        wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_item  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/ddo_cordic.sv -----
// iterative cordic: cosine and sine of a q3.28 heading, one rotation a cycle
module ddo_cordic #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);
  import ddo_pkg::*;

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, z0;
  logic [IW-1:0]      i_r;
  logic               busy_r, done_r, neg_r, neg0;

  assign done    = done_r;
  assign cos_q30 = neg_r ? -x_r : x_r;
  assign sin_q30 = neg_r ? -y_r : y_r;

  always_comb begin
    z0   = {angle, 2'b00};
    neg0 = 1'b0;
    if (z0 > HALF_PI_Q30) begin
      z0   = z0 - PI_Q30;
      neg0 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z0   = z0 + PI_Q30;
      neg0 = 1'b1;
    end
    if (!z_r[33]) begin
      x_nxt = x_r - (y_r >>> i_r);
      y_nxt = y_r + (x_r >>> i_r);
      z_nxt = z_r - atan_q30(5'(i_r));
    end else begin
      x_nxt = x_r + (y_r >>> i_r);
      y_nxt = y_r - (x_r >>> i_r);
      z_nxt = z_r + atan_q30(5'(i_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && i_r == IW'(STEPS - 1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
    if (start) begin
      x_r   <= GAIN_Q30;
      y_r   <= '0;
      z_r   <= z0;
      neg_r <= neg0;
      i_r   <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + IW'(1);
    end
  end

endmodule

// ----- rtl/ddo_back.sv -----
// back end: shared multiplier sequence, pose update and output register
module ddo_back #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ddo_pkg::ddo_item_t q_item,
  output logic               q_pop,
  input  logic [31:0]        mpc,
  input  logic [23:0]        iwb,
  input  logic [30:0]        thr,
  input  logic [15:0]        iper,
  input  logic               reload,
  input  logic [31:0]        start_x,
  input  logic [31:0]        start_y,
  input  logic [30:0]        start_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_pos_x,
  output logic [31:0]        out_pos_y,
  output logic [30:0]        out_heading,
  output logic [31:0]        out_fwd_rate,
  output logic [31:0]        out_turn_rate,
  output logic [31:0]        out_left_speed,
  output logic [31:0]        out_right_speed
);
  import ddo_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [3:0] OP_SUM    = 4'd0;
  localparam logic [3:0] OP_DIF    = 4'd1;
  localparam logic [3:0] OP_ENC_LO = 4'd2;
  localparam logic [3:0] OP_ENC_HI = 4'd3;
  localparam logic [3:0] OP_LEFT   = 4'd4;
  localparam logic [3:0] OP_RIGHT  = 4'd5;
  localparam logic [3:0] OP_FWD    = 4'd6;
  localparam logic [3:0] OP_TURN   = 4'd7;
  localparam logic [3:0] OP_DX     = 4'd8;
  localparam logic [3:0] OP_DY     = 4'd9;

  localparam logic [66:0] ENC_BIG = 67'h1_0000_0000;

  logic [1:0]         st_r, st_nxt;
  logic [3:0]         op_r;
  logic               ph_r;
  logic signed [66:0] p_r;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;

  logic [31:0]        pose_x_r, pose_y_r, pose_h_r;
  logic [31:0]        ds_r, enc_r, ls_r, rs_r, fv_r, tv_r, dx_r, dy_r;
  logic [56:0]        t1_r;
  logic [55:0]        lo_p_r;

  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        o_x_r, o_y_r, o_fv_r, o_tv_r, o_ls_r, o_rs_r;
  logic [30:0]        o_h_r;

  logic               cordic_start, cordic_done;
  logic signed [33:0] cos_q30, sin_q30;

  logic [31:0]        ds_mag, lc_mag, rc_mag, turn_mag;
  logic signed [33:0] dd, dd_mag, turn;
  logic [48:0]        hi_p;
  logic [66:0]        enc_m;
  logic signed [35:0] nh, load_h;
  logic               can_out;

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (pose_h_r),
    .done    (cordic_done),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  assign cordic_start = (st_r == ST_IDLE) && q_valid;
  assign can_out      = !out_valid_r || !out_stall;
  assign q_pop        = (st_r == ST_FIN) && can_out;

  assign out_valid       = out_valid_r;
  assign out_pos_x       = o_x_r;
  assign out_pos_y       = o_y_r;
  assign out_heading     = o_h_r;
  assign out_fwd_rate    = o_fv_r;
  assign out_turn_rate   = o_tv_r;
  assign out_left_speed  = o_ls_r;
  assign out_right_speed = o_rs_r;

  always_comb begin
    ds_mag = ds_r[31] ? 32'(-ds_r) : ds_r;
    lc_mag = q_item.lc[31] ? 32'(-q_item.lc) : 32'(q_item.lc);
    rc_mag = q_item.rc[31] ? 32'(-q_item.rc) : 32'(q_item.rc);
    // gyro wins when it disagrees with the wheels by more than the limit
    dd     = q_item.imu - 34'(signed'(enc_r));
    dd_mag = dd[33] ? -dd : dd;
    turn   = (dd_mag > 34'(thr)) ? q_item.imu : 34'(signed'(enc_r));
    turn_mag = turn[33] ? 32'(-turn) : turn[31:0];
    hi_p   = p_r[48:0];
    enc_m  = {36'b0, hi_p[10:0], 20'b0} + {23'b0, lo_p_r[55:12]};
    if (|hi_p[48:11]) begin
      enc_m = ENC_BIG;
    end
    nh     = wrap_pi(36'(signed'(pose_h_r)) + 36'(turn));
    load_h = wrap_pi(36'(signed'(start_h)));

    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (op_r)
      OP_SUM:    begin mul_a = {1'b0, q_item.sum_mag}; mul_b = {1'b0, mpc}; end
      OP_DIF:    begin mul_a = {1'b0, q_item.dif_mag}; mul_b = {1'b0, mpc}; end
      OP_ENC_LO: begin mul_a = {2'b0, t1_r[31:0]};     mul_b = {9'b0, iwb}; end
      OP_ENC_HI: begin mul_a = {9'b0, t1_r[56:32]};    mul_b = {9'b0, iwb}; end
      OP_LEFT:   begin mul_a = {2'b0, lc_mag};         mul_b = {1'b0, mpc}; end
      OP_RIGHT:  begin mul_a = {2'b0, rc_mag};         mul_b = {1'b0, mpc}; end
      OP_FWD:    begin mul_a = {2'b0, ds_mag};         mul_b = {17'b0, iper}; end
      OP_TURN:   begin mul_a = {2'b0, turn_mag};       mul_b = {17'b0, iper}; end
      OP_DX:     begin mul_a = 34'(signed'(ds_r));     mul_b = cos_q30[32:0]; end
      OP_DY:     begin mul_a = 34'(signed'(ds_r));     mul_b = sin_q30[32:0]; end
      default:   begin mul_a = '0;                     mul_b = '0; end
    endcase

    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        st_nxt = ST_RUN;
      end
      ST_RUN: if (ph_r && op_r == OP_DY) begin
        st_nxt = ST_FIN;
      end
      ST_FIN: if (can_out) begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_SUM;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (reload) begin
        pose_x_r <= start_x;
        pose_y_r <= start_y;
        pose_h_r <= load_h[31:0];
      end else if (q_pop) begin
        pose_x_r <= pose_x_r + dx_r;
        pose_y_r <= pose_y_r + dy_r;
        pose_h_r <= nh[31:0];
      end
      unique case (st_r)
        ST_IDLE: begin
          op_r <= OP_SUM;
          ph_r <= 1'b0;
        end
        ST_RUN: begin
          if (!ph_r) begin
            // rotation results are needed only for the last two products
            if (op_r < OP_DX || cordic_done) begin
              ph_r <= 1'b1;
            end
          end else begin
            ph_r <= 1'b0;
            if (op_r != OP_DY) begin
              op_r <= op_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end

    if (st_r == ST_RUN && !ph_r) begin
      p_r <= mul_a * mul_b;
    end
    if (st_r == ST_RUN && ph_r) begin
      unique case (op_r)
        OP_SUM:    ds_r   <= sat_mag(q_item.sum_neg, {17'b0, p_r[66:17]});
        OP_DIF:    t1_r   <= p_r[64:8];
        OP_ENC_LO: lo_p_r <= p_r[55:0];
        OP_ENC_HI: enc_r  <= sat_mag(q_item.dif_neg, enc_m);
        OP_LEFT:   ls_r   <= sat_mag(q_item.lc[31], {16'b0, p_r[66:16]});
        OP_RIGHT:  rs_r   <= sat_mag(q_item.rc[31], {16'b0, p_r[66:16]});
        OP_FWD:    fv_r   <= sat_mag(ds_r[31], p_r);
        OP_TURN:   tv_r   <= sat_mag(turn[33], {12'b0, p_r[66:12]});
        OP_DX:     dx_r   <= p_r[61:30];
        OP_DY:     dy_r   <= p_r[61:30];
        default: ;
      endcase
    end
    if (q_pop) begin
      o_x_r  <= pose_x_r + dx_r;
      o_y_r  <= pose_y_r + dy_r;
      o_h_r  <= nh[30:0];
      o_fv_r <= fv_r;
      o_tv_r <= tv_r;
      o_ls_r <= ls_r;
      o_rs_r <= rs_r;
    end
  end

endmodule

// ----- rtl/diff_drive_odometry_gyro_fusion.sv -----
// top level: configuration registers, front stage, queue and back end
//
// Dead-reckoning odometry for a differential-drive base with gyro fusion.
// Input channel (in_valid/in_stall) carries one word per control tick:
// left and right encoder count changes and the previous and current yaw.
// Output channel (out_valid/out_stall) returns one word per input word:
// updated pose, velocities and wheel travel, in the same order.
// A word is held in the front register, then waits in a two-entry queue.
// The back end runs ten products through one shared multiplier, each in a
// multiply phase and a store phase, while the cordic rotates the old
// heading, one step a cycle. A new word starts only when the previous one
// leaves the back end. The result sits in an output register; while
// out_stall is high it holds, the back end waits to retire the next word,
// and the queue then fills until in_stall rises. Reset empties the pipe,
// loads the register defaults and sets the pose to the start values. Any
// write to a known register reloads the pose from start_x, start_y and
// start_heading.
module diff_drive_odometry_gyro_fusion #(
  parameter int COUNT_BITS   = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COUNT_BITS-1:0] in_left_count,
  input  logic signed [COUNT_BITS-1:0] in_right_count,
  input  logic signed [31:0]           in_yaw_prev,
  input  logic signed [31:0]           in_yaw_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_pos_x,
  output logic signed [31:0]           out_pos_y,
  output logic signed [30:0]           out_heading,
  output logic signed [31:0]           out_fwd_rate,
  output logic signed [31:0]           out_turn_rate,
  output logic signed [31:0]           out_left_speed,
  output logic signed [31:0]           out_right_speed,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import ddo_pkg::*;

  logic [31:0] mpc_r, sx_r, sy_r;
  logic [23:0] iwb_r;
  logic [30:0] thr_r, sh_r;
  logic [15:0] iper_r;
  logic        reload_r, reload_nxt;

  logic        q_push, q_full, q_pop, q_valid;
  ddo_item_t   q_in, q_head;

  assign reload_nxt = cfg_we && (cfg_index < 3'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpc_r    <= RST_MPC;
      iwb_r    <= RST_IWB;
      thr_r    <= RST_THR;
      iper_r   <= RST_IPER;
      sx_r     <= '0;
      sy_r     <= '0;
      sh_r     <= '0;
      reload_r <= 1'b0;
    end else begin
      reload_r <= reload_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MPC:     mpc_r  <= cfg_data;
          REG_IWB:     iwb_r  <= cfg_data[23:0];
          REG_THR:     thr_r  <= cfg_data[30:0];
          REG_IPER:    iper_r <= cfg_data[15:0];
          REG_START_X: sx_r   <= cfg_data;
          REG_START_Y: sy_r   <= cfg_data;
          REG_START_H: sh_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  ddo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_yaw_prev    (in_yaw_prev),
    .in_yaw_now     (in_yaw_now),
    .q_push         (q_push),
    .q_item         (q_in),
    .q_full         (q_full)
  );

  ddo_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .mpc             (mpc_r),
    .iwb             (iwb_r),
    .thr             (thr_r),
    .iper            (iper_r),
    .reload          (reload_r),
    .start_x         (sx_r),
    .start_y         (sy_r),
    .start_h         (sh_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_heading     (out_heading),
    .out_fwd_rate    (out_fwd_rate),
    .out_turn_rate   (out_turn_rate),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed)
  );

endmodule

// ----- test/diff_drive_odometry_gyro_fusion_checker.sv -----
// watches the odometry channels, predicts each result word and compares
module diff_drive_odometry_gyro_fusion_checker #(
  parameter int COUNT_BITS   = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [COUNT_BITS-1:0] in_left_count,
  input  logic signed [COUNT_BITS-1:0] in_right_count,
  input  logic signed [31:0]           in_yaw_prev,
  input  logic signed [31:0]           in_yaw_now,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [31:0]           out_pos_x,
  input  logic signed [31:0]           out_pos_y,
  input  logic signed [30:0]           out_heading,
  input  logic signed [31:0]           out_fwd_rate,
  input  logic signed [31:0]           out_turn_rate,
  input  logic signed [31:0]           out_left_speed,
  input  logic signed [31:0]           out_right_speed,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import ddo_pkg::*;

  localparam longint ANG_PI      = 64'sd843314857;
  localparam longint ANG_TWO_PI  = 64'sd1686629713;
  localparam longint ROT_PI      = 64'sd3373259426;
  localparam longint ROT_HALF_PI = 64'sd1686629713;
  localparam longint ROT_GAIN    = 64'sd652032874;
  localparam longint unsigned PROD_CAP = 64'd1 << 62;

  localparam longint ARCTAN [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2};
  localparam int REG_BITS [NUM_REGS] = '{32, 24, 31, 16, 32, 32, 31};

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [30:0] heading;
    logic [31:0] fwd_rate;
    logic [31:0] turn_rate;
    logic [31:0] left_speed;
    logic [31:0] right_speed;
  } odo_word_t;

  longint unsigned cfg_regs [NUM_REGS];
  longint pose_x, pose_y, pose_h;
  odo_word_t expected_words [$];

  function automatic longint wrap_angle(input longint a);
    longint v;
    v = a;
    while (v > ANG_PI) v -= ANG_TWO_PI;
    while (v < -ANG_PI) v += ANG_TWO_PI;
    return v;
  endfunction

  // exact (m * w) >> s, capped at 2^62
  function automatic longint unsigned scaled(input longint unsigned m,
                                             input longint unsigned w, input int s);
    logic [127:0] p;
    p = ({64'd0, m} * {64'd0, w}) >> s;
    return (p > PROD_CAP) ? PROD_CAP : p[63:0];
  endfunction

  function automatic longint unsigned magnitude(input longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  function automatic longint with_sign(input longint a, input longint unsigned r);
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sext_bits(input longint unsigned v, input int bits);
    longint unsigned m;
    m = v & ((64'd1 << bits) - 1);
    return m[bits-1] ? longint'(m) - (64'sd1 <<< bits) : longint'(m);
  endfunction

  task automatic rotate_heading(input longint h, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = h * 4;
    x = ROT_GAIN;
    y = 0;
    flip = 0;
    if (z > ROT_HALF_PI) begin
      z -= ROT_PI;
      flip = 1;
    end else if (z < -ROT_HALF_PI) begin
      z += ROT_PI;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic reload_pose();
    pose_x = sext_bits(cfg_regs[REG_START_X], 32);
    pose_y = sext_bits(cfg_regs[REG_START_Y], 32);
    pose_h = wrap_angle(sext_bits(cfg_regs[REG_START_H], 31));
  endtask

  task automatic advance_pose(input longint lc, input longint rc, input longint yp,
                              input longint yn, output odo_word_t w);
    longint sum, dif, step, enc, imu, turn, c, s;
    longint unsigned mpc, iwb, ip;
    mpc = cfg_regs[REG_MPC];
    iwb = cfg_regs[REG_IWB];
    ip = cfg_regs[REG_IPER];
    sum = lc + rc;
    dif = rc - lc;
    step = sat32(with_sign(sum, scaled(magnitude(sum), mpc, 17)));
    enc = sat32(with_sign(dif, scaled(scaled(magnitude(dif), mpc, 8), iwb, 12)));
    imu = wrap_angle(yn) - wrap_angle(yp);
    // gyro wins only when it disagrees by more than the threshold
    turn = (magnitude(imu - enc) > cfg_regs[REG_THR]) ? imu : enc;
    rotate_heading(pose_h, c, s);
    pose_x = sext_bits(longint'(pose_x + ((step * c) >>> 30)), 32);
    pose_y = sext_bits(longint'(pose_y + ((step * s) >>> 30)), 32);
    pose_h = wrap_angle(pose_h + turn);
    w.pos_x = pose_x[31:0];
    w.pos_y = pose_y[31:0];
    w.heading = pose_h[30:0];
    w.fwd_rate = 32'(sat32(step * longint'(ip)));
    w.turn_rate = 32'(sat32(with_sign(turn, scaled(magnitude(turn), ip, 12))));
    w.left_speed = 32'(sat32(with_sign(lc, scaled(magnitude(lc), mpc, 16))));
    w.right_speed = 32'(sat32(with_sign(rc, scaled(magnitude(rc), mpc, 16))));
  endtask

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    odo_word_t w, e;
    if (!rst_n) begin
      fail_count = 0;
      cfg_regs[REG_MPC] = RST_MPC;
      cfg_regs[REG_IWB] = RST_IWB;
      cfg_regs[REG_THR] = RST_THR;
      cfg_regs[REG_IPER] = RST_IPER;
      cfg_regs[REG_START_X] = 0;
      cfg_regs[REG_START_Y] = 0;
      cfg_regs[REG_START_H] = 0;
      reload_pose();
      expected_words.delete();
    end else begin
      if (cfg_we && cfg_index < NUM_REGS) begin
        cfg_regs[cfg_index] = cfg_data & ((64'd1 << REG_BITS[cfg_index]) - 1);
        reload_pose();
      end
      if (in_valid && !in_stall) begin
        advance_pose(longint'(in_left_count), longint'(in_right_count),
                     longint'(in_yaw_prev), longint'(in_yaw_now), w);
        expected_words.push_back(w);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          check_field("pos_x", e.pos_x, out_pos_x);
          check_field("pos_y", e.pos_y, out_pos_y);
          check_field("heading", {1'b0, e.heading}, {1'b0, out_heading});
          check_field("fwd_rate", e.fwd_rate, out_fwd_rate);
          check_field("turn_rate", e.turn_rate, out_turn_rate);
          check_field("left_speed", e.left_speed, out_left_speed);
          check_field("right_speed", e.right_speed, out_right_speed);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- test/diff_drive_odometry_gyro_fusion_tb.sv -----
// stimulus and verdict for the odometry block with gyro fusion
module diff_drive_odometry_gyro_fusion_tb;
  import ddo_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] in_left_count = '0;
  logic signed [15:0] in_right_count = '0;
  logic signed [31:0] in_yaw_prev = '0;
  logic signed [31:0] in_yaw_now = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic signed [30:0] out_heading;
  logic signed [31:0] out_fwd_rate, out_turn_rate;
  logic signed [31:0] out_left_speed, out_right_speed;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 fail_count, pending;
  bit                 sender_quiet = 0, receiver_quiet = 0, hold_req = 0;

  diff_drive_odometry_gyro_fusion dut (.*);
  diff_drive_odometry_gyro_fusion_checker chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #5000000;
    $display("[diff_drive_odometry_gyro_fusion] ERROR");
    $finish;
  end

  // receiver: random stalls, a quiet window and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1;
      end else begin
        out_stall = !receiver_quiet && ($urandom_range(0, 99) < 16);
      end
    end
  end

  task automatic send_tick(input logic [15:0] l, input logic [15:0] r,
                           input logic [31:0] yp, input logic [31:0] yn);
    int gap;
    gap = (!sender_quiet && $urandom_range(0, 99) < 16) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_left_count = l;
    in_right_count = r;
    in_yaw_prev = yp;
    in_yaw_now = yn;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    in_valid = 0;
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_tick();
    logic [31:0] yp, yn;
    logic [15:0] l, r;
    int kind;
    kind = $urandom_range(0, 9);
    yp = $urandom;
    if (kind < 6) begin
      // plausible motion: small counts, yaw moving a little
      l = 16'($urandom_range(0, 600)) - 16'd300;
      r = l + 16'($urandom_range(0, 40)) - 16'd20;
      yn = yp + 32'($urandom_range(0, 2097152)) - 32'd1048576;
    end else if (kind < 8) begin
      l = $urandom;
      r = $urandom;
      yn = $urandom;
    end else if (kind == 8) begin
      l = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      r = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      yn = $urandom;
    end else begin
      l = $urandom_range(0, 20);
      r = l;
      yn = yp;
    end
    send_tick(l, r, yp, yn);
  endtask

  initial begin
    logic [31:0] v [NUM_REGS];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_tick(16'd0, 16'd0, 32'd0, 32'd0);
    send_tick(16'h7FFF, 16'h7FFF, 32'd0, 32'd0);
    send_tick(16'h8000, 16'h8000, 32'd0, 32'd0);
    send_tick(16'h8000, 16'h7FFF, 32'd0, 32'd0);
    send_tick(16'h7FFF, 16'h8000, 32'd5, 32'd5);
    send_tick(16'd100, -16'sd100, 32'd0, 32'd0);
    send_tick(16'd1, 16'd2, 32'd0, 32'd0);
    send_tick(16'd50, 16'd50, 32'h7FFFFFFF, 32'h80000000);
    send_tick(16'd50, 16'd60, 32'd843314857, -32'sd843314857);
    send_tick(16'd40, 16'd40, 32'd843314858, 32'd0);
    send_tick(16'd0, 16'd0, -32'sd843314858, 32'd843314857);
    send_tick(16'hFFFF, 16'd1, 32'h80000000, 32'h7FFFFFFF);
    repeat (6) send_tick(16'd300, 16'd300, 32'd0, 32'd0);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: v = '{32'hFFFFFFFF, 32'hFFFFFF, 32'h7FFFFFFF, 32'hFFFF,
                 32'h7FFFFFFF, 32'h80000000, 32'd843314857};
        1: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF,
                 32'h40000000};
        2: v = '{RST_MPC, RST_IWB, RST_THR, RST_IPER, 32'd0, 32'd0, 32'h3FFFFFFF};
        default: v = '{$urandom, $urandom_range(0, 24'hFFFFFF), $urandom,
                       $urandom_range(1, 65535), $urandom, $urandom, $urandom};
      endcase
      write_reg(REG_MPC, v[0]);
      write_reg(REG_IWB, v[1]);
      write_reg(REG_THR, v[2]);
      write_reg(REG_IPER, v[3]);
      write_reg(REG_START_X, v[4]);
      write_reg(REG_START_Y, v[5]);
      write_reg(REG_START_H, v[6]);
      write_reg(REG_UNUSED, $urandom);
      sender_quiet = (p == 3);
      receiver_quiet = (p == 4);
      hold_req = (p == 5);
      repeat (80) random_tick();
    end

    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[diff_drive_odometry_gyro_fusion] OK");
    end else begin
      $display("[diff_drive_odometry_gyro_fusion] ERROR");
    end
    $finish;
  end

endmodule
